@@ rtl/servo_angle_ramp_to_duty_macros.svh @@
// Assertion macros for the servo angle / duty block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef SERVO_ANGLE_RAMP_TO_DUTY_MACROS_SVH
`define SERVO_ANGLE_RAMP_TO_DUTY_MACROS_SVH

// Condition must hold at every edge out of reset.
`define SVAR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SVAR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/svar_pkg.sv @@
// Package for the servo angle / duty block: angle limits, command codes,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package svar_pkg;

	localparam int DUTY_BITS_DEFAULT = 14;
	localparam int ANGLE_BITS        = 8;
	localparam int DELAY_BITS        = 16;
	localparam int KIND_BITS         = 3;
	localparam int CFG_IDX_BITS      = 2;

	localparam int ANGLE_MAX   = 180;
	localparam int ANGLE_RESET = 140;

	localparam int DUTY_LO_RESET = 410;
	localparam int DUTY_HI_RESET = 2048;

	// command codes
	localparam logic [KIND_BITS-1:0] KIND_SET    = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_SMOOTH = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_RIGHT  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_LEFT   = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_LO = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_HI = 2'd1;

endpackage

@@ rtl/servo_angle_ramp_to_duty.sv @@
// Servo angle keeper with slew ramp, producing a PWM duty count.
// Depends on svar_pkg and servo_angle_ramp_to_duty_macros.svh.
//
// Usage
//   Command channel (cmd_valid / cmd_stall): kind, amount, step_delay.
//   Result channel (res_valid / res_stall): duty, angle, moving.
//   Config port: cfg_we, cfg_index (0 duty at 0 deg, 1 duty at 180 deg), cfg_wdata;
//   write only while no command is in flight.
//   An item taken shows its result, if it has one, after five register stages
//   (input, angle state, span product, reciprocal product, result). Ticks that
//   do not step the ramp, ticks while idle and unknown kinds give no result.
//   Throughput is one item per cycle unless res_stall holds the pipe; the angle state
//   is written from the input register, so back-to-back commands see each other's effect.
//   The divide by 180 is a multiply by a reciprocal with a one-step fixup.
//   If res_stall is high while a result waits, the whole pipe holds and
//   cmd_stall rises in the same cycle; a result in the output register
//   stays put until taken.
//   Reset: angle 140, no ramp, duty counts 410 at 0 deg and 2048 at 180 deg, pipe empty.
`timescale 1ns / 1ps
`include "servo_angle_ramp_to_duty_macros.svh"

module servo_angle_ramp_to_duty #(
	parameter int DUTY_BITS = svar_pkg::DUTY_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command channel
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [svar_pkg::KIND_BITS-1:0]    kind,
	input  logic [svar_pkg::ANGLE_BITS-1:0]   amount,
	input  logic [svar_pkg::DELAY_BITS-1:0]   step_delay,
	// result channel
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [DUTY_BITS-1:0]              duty,
	output logic [svar_pkg::ANGLE_BITS-1:0]   angle,
	output logic                              moving,
	// configuration
	input  logic                              cfg_we,
	input  logic [svar_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DUTY_BITS-1:0]              cfg_wdata
);

	localparam int AW    = svar_pkg::ANGLE_BITS;
	localparam int DW    = svar_pkg::DELAY_BITS;
	localparam int PW    = DUTY_BITS + AW;         // span * angle
	localparam int XW    = PW - 2;                 // product / 4
	localparam int RW    = XW - 5;                 // reciprocal of 45
	localparam int MW    = XW + RW;                // reciprocal product
	localparam int QW    = MW - XW;                // coarse quotient
	localparam int QDIV  = svar_pkg::ANGLE_MAX / 4;
	localparam longint unsigned RECIP_FULL = (64'd1 << XW) / QDIV;
	localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

	localparam logic [AW-1:0] A_MAX   = AW'(svar_pkg::ANGLE_MAX);
	localparam logic [AW-1:0] A_RESET = AW'(svar_pkg::ANGLE_RESET);
	localparam logic [DW-1:0] D_ONE   = DW'(1);

	// configuration
	logic [DUTY_BITS-1:0] duty_lo_q, duty_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_lo_q <= DUTY_BITS'(svar_pkg::DUTY_LO_RESET);
			duty_hi_q <= DUTY_BITS'(svar_pkg::DUTY_HI_RESET);
		end else if (cfg_we) begin
			if (cfg_index == svar_pkg::REG_DUTY_LO) begin
				duty_lo_q <= cfg_wdata;
			end else if (cfg_index == svar_pkg::REG_DUTY_HI) begin
				duty_hi_q <= cfg_wdata;
			end
		end
	end

	// whole pipe moves together unless a result is held
	logic adv;
	assign adv       = !res_valid || !res_stall;
	assign cmd_stall = !adv;

	// stage 1: input register
	logic                  v_s1;
	logic [2:0]            kind_s1;
	logic [AW-1:0]         amount_s1;
	logic [DW-1:0]         delay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd_valid) begin
			kind_s1   <= kind;
			amount_s1 <= amount;
			delay_s1  <= step_delay;
		end
	end

	// angle state
	logic [AW-1:0] cur_q, tgt_q;
	logic [DW-1:0] left_q, reload_q;
	logic          ramp_q;

	logic [AW-1:0] cur_n, tgt_n, clamped, stepped;
	logic [DW-1:0] left_n, reload_n;
	logic          ramp_n, emit_n;
	logic [AW:0]   sum_left;

	always_comb begin
		clamped  = (amount_s1 > A_MAX) ? A_MAX : amount_s1;
		sum_left = {1'b0, cur_q} + {1'b0, amount_s1};
		// one degree toward the target in force for this command
		if (kind_s1 == svar_pkg::KIND_SMOOTH) begin
			tgt_n = clamped;
		end else begin
			tgt_n = tgt_q;
		end
		if (tgt_n > cur_q) begin
			stepped = cur_q + AW'(1);
		end else if (tgt_n < cur_q) begin
			stepped = cur_q - AW'(1);
		end else begin
			stepped = cur_q;
		end

		cur_n    = cur_q;
		left_n   = left_q;
		reload_n = reload_q;
		ramp_n   = ramp_q;
		emit_n   = 1'b0;

		unique case (kind_s1)
			svar_pkg::KIND_SET: begin
				cur_n  = clamped;
				tgt_n  = clamped;
				ramp_n = 1'b0;
				emit_n = 1'b1;
			end
			svar_pkg::KIND_SMOOTH: begin
				cur_n  = stepped;
				ramp_n = 1'b0;
				emit_n = 1'b1;
				if (stepped != clamped) begin
					reload_n = (delay_s1 == '0) ? D_ONE : delay_s1;
					left_n   = reload_n;
					ramp_n   = 1'b1;
				end
			end
			svar_pkg::KIND_RIGHT: begin
				cur_n  = (amount_s1 >= cur_q) ? '0 : cur_q - amount_s1;
				tgt_n  = cur_n;
				ramp_n = 1'b0;
				emit_n = 1'b1;
			end
			svar_pkg::KIND_LEFT: begin
				cur_n  = (sum_left > {1'b0, A_MAX}) ? A_MAX : sum_left[AW-1:0];
				tgt_n  = cur_n;
				ramp_n = 1'b0;
				emit_n = 1'b1;
			end
			svar_pkg::KIND_TICK: begin
				if (ramp_q) begin
					if (left_q > D_ONE) begin
						left_n = left_q - D_ONE;
					end else begin
						cur_n  = stepped;
						emit_n = 1'b1;
						if (stepped == tgt_q) begin
							ramp_n = 1'b0;
							left_n = '0;
						end else begin
							left_n = (reload_q == '0) ? D_ONE : reload_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= A_RESET;
			tgt_q    <= A_RESET;
			left_q   <= '0;
			reload_q <= '0;
			ramp_q   <= 1'b0;
		end else if (adv && v_s1) begin
			cur_q    <= cur_n;
			tgt_q    <= tgt_n;
			left_q   <= left_n;
			reload_q <= reload_n;
			ramp_q   <= ramp_n;
		end
	end

	// stage 2: result angle and flag
	logic          v_s2, moving_s2;
	logic [AW-1:0] angle_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s2  <= cur_n;
			moving_s2 <= ramp_n;
		end
	end

	// stage 3: span * angle
	logic [DUTY_BITS-1:0] span;
	assign span = (duty_hi_q >= duty_lo_q) ? (duty_hi_q - duty_lo_q) : '0;

	logic          v_s3, moving_s3;
	logic [AW-1:0] angle_s3;
	logic [PW-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s3  <= angle_s2;
			moving_s3 <= moving_s2;
			prod_s3   <= PW'(span) * PW'(angle_s2);
		end
	end

	// stage 4: (p / 4) * floor(2^XW / 45); p / 180 == (p / 4) / 45
	logic          v_s4, moving_s4;
	logic [AW-1:0] angle_s4;
	logic [XW-1:0] x_s4;
	logic [MW-1:0] recip_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s4  <= angle_s3;
			moving_s4 <= moving_s3;
			x_s4      <= prod_s3[PW-1:2];
			recip_s4  <= MW'(prod_s3[PW-1:2]) * MW'(RECIP);
		end
	end

	// result: coarse quotient is at most one short, fix with one compare
	logic [QW-1:0]        q0;
	logic [XW:0]          q45, rem;
	logic [DUTY_BITS-1:0] quot;

	always_comb begin
		q0   = recip_s4[MW-1:XW];
		q45  = (XW+1)'(q0) * (XW+1)'(QDIV);
		rem  = {1'b0, x_s4} - q45;
		quot = DUTY_BITS'(q0) + ((rem >= (XW+1)'(QDIV)) ? DUTY_BITS'(1) : '0);
	end

	logic                 res_valid_q, moving_q;
	logic [AW-1:0]        angle_q;
	logic [DUTY_BITS-1:0] duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q  <= angle_s4;
			moving_q <= moving_s4;
			duty_q   <= duty_lo_q + quot;
		end
	end

	assign res_valid = res_valid_q;
	assign duty      = duty_q;
	assign angle     = angle_q;
	assign moving    = moving_q;

	// checks
	`SVAR_ASSERT_ALWAYS(a_angle_range, cur_q <= A_MAX, "angle state beyond 180")
	`SVAR_ASSERT_IMP(a_ramp_not_done, ramp_q, cur_q != tgt_q, "ramp running at its target")
	`SVAR_ASSERT_IMP(a_ramp_delay, ramp_q, left_q != '0, "ramp running with no delay left")
	`SVAR_ASSERT_IMP(a_s2_matches_state, v_s2,
		(angle_s2 == cur_q) && (moving_s2 == ramp_q), "stage 2 result differs from state")

endmodule

@@ verif/tb_servo_angle_ramp_to_duty.sv @@
// Self-checking bench for servo_angle_ramp_to_duty: directed and random commands,
// with a predictor of the angle, ramp and duty state, under random stalls and gaps.
// Depends on svar_pkg and the RTL of servo_angle_ramp_to_duty.
`timescale 1ns / 1ps

module tb_servo_angle_ramp_to_duty;

	localparam int DUTY_BITS    = svar_pkg::DUTY_BITS_DEFAULT;
	localparam int ANGLE_BITS   = svar_pkg::ANGLE_BITS;
	localparam int DELAY_BITS   = svar_pkg::DELAY_BITS;
	localparam int KIND_BITS    = svar_pkg::KIND_BITS;
	localparam int CFG_IDX_BITS = svar_pkg::CFG_IDX_BITS;
	localparam int ANGLE_MAX    = svar_pkg::ANGLE_MAX;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [ANGLE_BITS-1:0] amount;
		logic [DELAY_BITS-1:0] step_delay;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0]  duty;
		logic [ANGLE_BITS-1:0] angle;
		logic                  moving;
	} servo_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    cmd_valid = 1'b0;
	logic                    cmd_stall;
	logic [KIND_BITS-1:0]    kind = '0;
	logic [ANGLE_BITS-1:0]   amount = '0;
	logic [DELAY_BITS-1:0]   step_delay = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [DUTY_BITS-1:0]    duty;
	logic [ANGLE_BITS-1:0]   angle;
	logic                    moving;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [DUTY_BITS-1:0]    cfg_wdata = '0;

	servo_angle_ramp_to_duty #(.DUTY_BITS(DUTY_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.kind(kind), .amount(amount), .step_delay(step_delay),
		.res_valid(res_valid), .res_stall(res_stall),
		.duty(duty), .angle(angle), .moving(moving),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// shadow of the block's state and registers
	logic [ANGLE_BITS-1:0] cur_ang = ANGLE_BITS'(svar_pkg::ANGLE_RESET);
	logic [ANGLE_BITS-1:0] tgt_ang = ANGLE_BITS'(svar_pkg::ANGLE_RESET);
	logic [DELAY_BITS-1:0] dly_left = '0;
	logic [DELAY_BITS-1:0] dly_reload = '0;
	logic                  ramp_on = 1'b0;
	logic [DUTY_BITS-1:0]  duty_lo_q = DUTY_BITS'(svar_pkg::DUTY_LO_RESET);
	logic [DUTY_BITS-1:0]  duty_hi_q = DUTY_BITS'(svar_pkg::DUTY_HI_RESET);

	cmd_t       cmd_q[$];
	servo_res_t angle_duty_q[$];

	bit idle_on = 1'b1;
	int n_pushed = 0;
	int n_ignored = 0;
	int n_checked = 0;
	int n_tick_steps = 0;
	int n_settings = 1;
	int n_mismatch = 0;
	int send_gap = 0;
	int stall_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_servo_angle_ramp_to_duty: FAIL");
		$finish;
	end

	// mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DUTY_BITS-1:0] duty_for(input logic [ANGLE_BITS-1:0] a);
		int unsigned span;
		span = (duty_hi_q >= duty_lo_q) ? int'(duty_hi_q) - int'(duty_lo_q) : 0;
		return DUTY_BITS'(int'(duty_lo_q) + (span * a) / ANGLE_MAX);
	endfunction

	function void step_one_degree();
		if (tgt_ang > cur_ang)
			cur_ang = cur_ang + 1'b1;
		else if (tgt_ang < cur_ang)
			cur_ang = cur_ang - 1'b1;
	endfunction

	// applies one command to the shadow state; returns 1 when it yields a result
	function bit servo_cmd_apply(input cmd_t c, output servo_res_t r);
		logic [ANGLE_BITS-1:0] clamped;
		int unsigned sum;
		bit emit;
		clamped = (c.amount > ANGLE_MAX) ? ANGLE_BITS'(ANGLE_MAX) : c.amount;
		emit = 1'b1;
		unique case (c.kind)
			svar_pkg::KIND_SET: begin
				ramp_on = 1'b0;
				cur_ang = clamped;
				tgt_ang = clamped;
			end
			svar_pkg::KIND_SMOOTH: begin
				ramp_on = 1'b0;
				tgt_ang = clamped;
				if (cur_ang != tgt_ang) begin
					step_one_degree();
					if (cur_ang != tgt_ang) begin
						dly_reload = (c.step_delay == '0) ? DELAY_BITS'(1) : c.step_delay;
						dly_left = dly_reload;
						ramp_on = 1'b1;
					end
				end
			end
			svar_pkg::KIND_RIGHT: begin
				ramp_on = 1'b0;
				cur_ang = (c.amount >= cur_ang) ? '0 : cur_ang - c.amount;
				tgt_ang = cur_ang;
			end
			svar_pkg::KIND_LEFT: begin
				ramp_on = 1'b0;
				sum = int'(cur_ang) + int'(c.amount);
				cur_ang = (sum > ANGLE_MAX) ? ANGLE_BITS'(ANGLE_MAX) : ANGLE_BITS'(sum);
				tgt_ang = cur_ang;
			end
			svar_pkg::KIND_TICK: begin
				if (!ramp_on) begin
					emit = 1'b0;
				end else if (dly_left > 1) begin
					dly_left = dly_left - 1'b1;
					emit = 1'b0;
				end else begin
					step_one_degree();
					if (cur_ang == tgt_ang) begin
						ramp_on = 1'b0;
						dly_left = '0;
					end else begin
						dly_left = (dly_reload == '0) ? DELAY_BITS'(1) : dly_reload;
					end
					n_tick_steps++;
				end
			end
			default: emit = 1'b0;
		endcase
		r.duty = duty_for(cur_ang);
		r.angle = cur_ang;
		r.moving = ramp_on;
		return emit;
	endfunction

	// driver: prediction happens at the edge that takes the item
	always @(posedge clk or negedge arst_n) begin
		cmd_t nxt;
		servo_res_t res;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			kind <= '0;
			amount <= '0;
			step_delay <= '0;
			send_gap = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				if (servo_cmd_apply({kind, amount, step_delay}, res))
					angle_duty_q.push_back(res);
			end
			if (cmd_valid && cmd_stall) begin
				// held until taken
			end else if (send_gap > 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				nxt = cmd_q.pop_front();
				kind <= nxt.kind;
				amount <= nxt.amount;
				step_delay <= nxt.step_delay;
				cmd_valid <= 1'b1;
				send_gap = idle_on ? gap_len() : 0;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// monitor and result-side stalls
	always @(posedge clk or negedge arst_n) begin
		servo_res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (angle_duty_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: unexpected result: duty %0d angle %0d moving %0b",
							$time, duty, angle, moving);
				end else begin
					want = angle_duty_q.pop_front();
					n_checked++;
					if (duty !== want.duty || angle !== want.angle || moving !== want.moving) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("%0t: mismatch: exp duty %0d angle %0d moving %0b,",
								$time, want.duty, want.angle, want.moving);
							$display("%0t:           got duty %0d angle %0d moving %0b",
								$time, duty, angle, moving);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (idle_on)
					stall_left = gap_len();
			end
		end
	end

	task automatic push_cmd(input logic [KIND_BITS-1:0] k, input int unsigned a,
			input int unsigned d);
		cmd_t c;
		c.kind = k;
		c.amount = ANGLE_BITS'(a);
		c.step_delay = DELAY_BITS'(d);
		cmd_q.push_back(c);
		if (k > svar_pkg::KIND_TICK)
			n_ignored++;
		else
			n_pushed++;
	endtask

	// waits until every item is taken and every result has come back
	task automatic wait_quiet();
		while (cmd_q.size() != 0 || cmd_valid || angle_duty_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= DUTY_BITS'(val);
		if (idx == svar_pkg::REG_DUTY_LO)
			duty_lo_q = DUTY_BITS'(val);
		else if (idx == svar_pkg::REG_DUTY_HI)
			duty_hi_q = DUTY_BITS'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_random(input int budget);
		int start, r, a, b, d, dl, nt, i;
		start = n_pushed;
		while (n_pushed - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				// ramp: optional set, smooth move, then up to 40 ticks, about as many as the ramp needs
				a = $urandom_range(0, ANGLE_MAX);
				if ($urandom_range(0, 3) != 0)
					push_cmd(svar_pkg::KIND_SET, a, $urandom);
				d = $urandom_range(0, 12);
				b = $urandom_range(0, 1) ? a + d : a - d;
				if (b < 0)
					b = 0;
				if ($urandom_range(0, 9) == 0)
					b = $urandom_range(ANGLE_MAX + 1, 255);
				dl = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 65535)
					: $urandom_range(0, 3);
				push_cmd(svar_pkg::KIND_SMOOTH, b, dl);
				nt = d * ((dl == 0) ? 1 : dl) + $urandom_range(0, 4) - 2;
				if (nt > 40)
					nt = 40;
				for (i = 0; i < nt; i++) begin
					if ($urandom_range(0, 59) == 0)
						push_cmd(svar_pkg::KIND_RIGHT + KIND_BITS'($urandom_range(0, 1)),
							$urandom_range(0, 255), $urandom);
					push_cmd(svar_pkg::KIND_TICK, $urandom_range(0, 255), $urandom);
				end
			end else if (r < 60) begin
				push_cmd(svar_pkg::KIND_SET, $urandom_range(0, 255), $urandom);
			end else if (r < 75) begin
				push_cmd(svar_pkg::KIND_RIGHT + KIND_BITS'($urandom_range(0, 1)),
					$urandom_range(0, 2) == 0 ? $urandom_range(0, 10) : $urandom_range(0, 255),
					$urandom);
			end else if (r < 85) begin
				push_cmd(svar_pkg::KIND_TICK, $urandom_range(0, 255), $urandom);
			end else if (r < 92) begin
				push_cmd(svar_pkg::KIND_SMOOTH, $urandom_range(0, 255), $urandom_range(0, 65535));
				for (i = $urandom_range(1, 3); i > 0; i--)
					push_cmd(svar_pkg::KIND_TICK, $urandom_range(0, 255), $urandom);
			end else begin
				push_cmd(KIND_BITS'($urandom_range(svar_pkg::KIND_TICK + 1,
					(1 << KIND_BITS) - 1)), $urandom_range(0, 255), $urandom);
			end
		end
	endtask

	initial begin
		int ph, lo, hi;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset registers, angle starts at 140
		idle_on = 1'b0;
		push_cmd(svar_pkg::KIND_TICK, 0, 0);              // tick with no ramp
		push_cmd(svar_pkg::KIND_TICK + 3'd1, 255, 65535); // unknown codes
		push_cmd(svar_pkg::KIND_TICK + 3'd2, 0, 0);
		push_cmd(svar_pkg::KIND_TICK + 3'd3, 90, 1);
		push_cmd(svar_pkg::KIND_SET, 0, 0);
		push_cmd(svar_pkg::KIND_SET, 255, 0);             // clamps to the top
		push_cmd(svar_pkg::KIND_LEFT, 255, 0);            // saturates high
		push_cmd(svar_pkg::KIND_RIGHT, 255, 0);           // saturates low
		push_cmd(svar_pkg::KIND_RIGHT, 0, 0);
		push_cmd(svar_pkg::KIND_LEFT, 90, 0);
		push_cmd(svar_pkg::KIND_SMOOTH, 90, 7);           // move to where it already is
		push_cmd(svar_pkg::KIND_SMOOTH, 91, 5);           // one degree, done at once
		push_cmd(svar_pkg::KIND_SMOOTH, 95, 0);           // zero delay acts as one tick
		push_cmd(svar_pkg::KIND_TICK, 0, 0);
		push_cmd(svar_pkg::KIND_TICK, 255, 65535);
		push_cmd(svar_pkg::KIND_TICK, 0, 0);
		push_cmd(svar_pkg::KIND_SMOOTH, 255, 65535);      // long ramp, then cancelled
		push_cmd(svar_pkg::KIND_TICK, 0, 0);
		push_cmd(svar_pkg::KIND_SET, 100, 0);
		push_cmd(svar_pkg::KIND_TICK, 0, 0);
		push_cmd(svar_pkg::KIND_SMOOTH, 97, 2);
		push_cmd(svar_pkg::KIND_TICK, 0, 0);
		push_cmd(svar_pkg::KIND_TICK, 0, 0);
		push_cmd(svar_pkg::KIND_SMOOTH, 0, 1);
		push_cmd(svar_pkg::KIND_LEFT, 3, 0);              // turn cancels the ramp
		wait_quiet();

		for (ph = 0; ph < 6; ph++) begin
			unique case (ph)
				0: begin lo = 0; hi = (1 << DUTY_BITS) - 1; end
				1: begin lo = (1 << DUTY_BITS) - 1; hi = 0; end      // span saturates
				2: begin lo = $urandom_range(0, 16383); hi = $urandom_range(0, 16383); end
				3: begin lo = (1 << DUTY_BITS) - 1; hi = lo; end
				4: begin lo = 0; hi = 0; end
				default: begin lo = $urandom_range(0, 4000); hi = $urandom_range(lo, 16383); end
			endcase
			write_reg(svar_pkg::REG_DUTY_LO, lo);
			write_reg(svar_pkg::REG_DUTY_HI, hi);
			if (ph == 2)
				write_reg(svar_pkg::REG_DUTY_HI + 2'd1, $urandom); // no such register
			n_settings++;
			@(negedge clk);
			idle_on = (ph != 2);
			add_random(43);
			wait_quiet();                                        // sender holds off
			add_random(42);
			wait_quiet();
		end

		$display("Ran %0d commands plus %0d undefined codes over %0d register settings;",
			n_pushed, n_ignored, n_settings);
		$display("checked %0d results, %0d of them ramp steps on ticks.",
			n_checked, n_tick_steps);
		if (n_mismatch == 0 && angle_duty_q.size() == 0)
			$display("tb_servo_angle_ramp_to_duty: PASS");
		else
			$display("tb_servo_angle_ramp_to_duty: FAIL");
		$finish;
	end

endmodule
